// File: src/refcounted_page_allocator_top_assert.svh
// Assertion macros for the page allocator top level.
// Depends on nothing; included inside module bodies.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define RCPA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rcpa assertion failed");

// next-cycle implication
`define RCPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rcpa assertion failed");

`endif

// File: src/rcpa_pkg.sv
// Shared types and codes for the refcounted page allocator.
// No dependencies.
package rcpa_pkg;

  localparam int ADDR_W     = 27;
  localparam int LIMIT_W    = 28;
  localparam int COUNT_W    = 16;
  localparam int PAGE_SHIFT = 12;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [2:0] OP_ALLOC     = 3'd0;
  localparam logic [2:0] OP_FREE      = 3'd1;
  localparam logic [2:0] OP_SEED_FREE = 3'd2;
  localparam logic [2:0] OP_INC       = 3'd3;
  localparam logic [2:0] OP_DEC       = 3'd4;
  localparam logic [2:0] OP_READ      = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_ADDR  = 3'd1;
  localparam logic [2:0] ST_NO_MEM    = 3'd2;
  localparam logic [2:0] ST_HAS_REFS  = 3'd3;
  localparam logic [2:0] ST_UNDERFLOW = 3'd4;
  localparam logic [2:0] ST_SATURATED = 3'd5;

  localparam logic CFG_LOW_LIMIT = 1'b0;
  localparam logic CFG_TOP_LIMIT = 1'b1;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [ADDR_W-1:0] page_address;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [ADDR_W-1:0]  alloc_address;
    logic [COUNT_W-1:0] ref_count;
    logic               page_freed;
  } rsp_t;

endpackage

// File: src/refcounted_page_allocator_top.sv
// Refcounted page allocator: LIFO free list plus per-page reference counts.
// Result: an accepted request is registered into EXEC; the result register is loaded from EXEC once the output is free.
// Requests: req_stall stays high in EXEC, so a new request is taken only after the last result is registered.
// Reset: synchronous; a clearing pass zeroes each of the PAGE_COUNT entries of the count
// RAM while req_stall stays high. Limit writes are taken during the pass.
// Depends on rcpa_pkg, rcpa_ram and the assertion macro header.
module refcounted_page_allocator_top #(
  parameter int PAGE_COUNT = 32768
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [rcpa_pkg::LIMIT_W-1:0] cfg_data,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  rcpa_pkg::req_t              req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output rcpa_pkg::rsp_t              rsp
);
  import rcpa_pkg::*;

  `include "refcounted_page_allocator_top_assert.svh"

  localparam int IDX_W = $clog2(PAGE_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAGE_COUNT - 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} state_t;

  state_t              state;
  logic [IDX_W-1:0]    clr_idx;
  logic [LIMIT_W-1:0]  low_limit;
  logic [LIMIT_W-1:0]  top_limit;
  logic                head_valid;
  logic [IDX_W-1:0]    head_idx;
  logic [2:0]          op_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [IDX_W-1:0]    idx_q;

  logic                req_fire;
  logic                out_free;
  logic                do_exec;
  logic [31:0]         req_idx32;
  logic [IDX_W-1:0]    req_idx;

  // RAM ports
  logic                ref_we;
  logic [IDX_W-1:0]    ref_waddr;
  logic [COUNT_W-1:0]  ref_wdata;
  logic [IDX_W-1:0]    rd_addr;
  logic [COUNT_W-1:0]  ref_rdata;
  logic                link_we;
  logic [IDX_W:0]      link_wdata;
  logic [IDX_W:0]      link_rdata;

  // execute-stage results
  logic                bad_addr;
  logic [31:0]         exec_idx32;
  logic [31:0]         head_idx32;
  logic                ex_ref_we;
  logic [COUNT_W-1:0]  ex_ref_wdata;
  logic                ex_push;
  logic                ex_pop;
  rsp_t                ex_rsp;

  assign req_stall = (state != S_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign do_exec   = (state == S_EXEC) && out_free;

  assign req_idx32 = {{(32-(ADDR_W-PAGE_SHIFT)){1'b0}}, req.page_address[ADDR_W-1:PAGE_SHIFT]};
  assign req_idx   = req_idx32[IDX_W-1:0];

  // read address: alloc reads the list head, everything else its page;
  // held in EXEC so a stalled result re-reads the same entry
  always_comb begin
    if (state == S_IDLE) begin
      rd_addr = (req.opcode == OP_ALLOC) ? head_idx : req_idx;
    end else begin
      rd_addr = idx_q;
    end
  end

  always_comb begin
    exec_idx32 = {{(32-(ADDR_W-PAGE_SHIFT)){1'b0}}, addr_q[ADDR_W-1:PAGE_SHIFT]};
    head_idx32 = 32'(head_idx);
    bad_addr   = (addr_q[PAGE_SHIFT-1:0] != '0)
              || ({1'b0, addr_q} < low_limit)
              || ({1'b0, addr_q} >= top_limit)
              || (exec_idx32 >= 32'(PAGE_COUNT));

    ex_rsp       = '0;
    ex_ref_we    = 1'b0;
    ex_ref_wdata = ref_rdata;
    ex_push      = 1'b0;
    ex_pop       = 1'b0;

    if (op_q == OP_ALLOC) begin
      if (!head_valid) begin
        ex_rsp.status = ST_NO_MEM;
      end else begin
        ex_pop               = 1'b1;
        ex_ref_we            = 1'b1;
        ex_ref_wdata         = COUNT_W'(1);
        ex_rsp.alloc_address = {head_idx32[ADDR_W-PAGE_SHIFT-1:0], {PAGE_SHIFT{1'b0}}};
        ex_rsp.ref_count     = COUNT_W'(1);
      end
    end else if (op_q <= OP_READ) begin
      if (bad_addr) begin
        ex_rsp.status = ST_BAD_ADDR;
      end else begin
        case (op_q)
          OP_FREE: begin
            if (ref_rdata != '0) begin
              ex_rsp.status    = ST_HAS_REFS;
              ex_rsp.ref_count = ref_rdata;
            end else begin
              ex_push           = 1'b1;
              ex_rsp.page_freed = 1'b1;
            end
          end
          OP_SEED_FREE: begin
            ex_push           = 1'b1;
            ex_rsp.page_freed = 1'b1;
            ex_rsp.ref_count  = ref_rdata;
          end
          OP_INC: begin
            if (ref_rdata == COUNT_MAX) begin
              ex_rsp.status    = ST_SATURATED;
              ex_rsp.ref_count = COUNT_MAX;
            end else begin
              ex_ref_we        = 1'b1;
              ex_ref_wdata     = ref_rdata + COUNT_W'(1);
              ex_rsp.ref_count = ex_ref_wdata;
            end
          end
          OP_DEC: begin
            if (ref_rdata == '0) begin
              ex_rsp.status = ST_UNDERFLOW;
            end else begin
              ex_ref_we        = 1'b1;
              ex_ref_wdata     = ref_rdata - COUNT_W'(1);
              ex_rsp.ref_count = ex_ref_wdata;
              if (ex_ref_wdata == '0) begin
                ex_push           = 1'b1;
                ex_rsp.page_freed = 1'b1;
              end
            end
          end
          default: begin
            ex_rsp.ref_count = ref_rdata;
          end
        endcase
      end
    end
  end

  // write ports: clearing pass owns the count RAM until it finishes
  always_comb begin
    if (state == S_CLEAR) begin
      ref_we    = 1'b1;
      ref_waddr = clr_idx;
      ref_wdata = '0;
    end else begin
      ref_we    = do_exec && ex_ref_we;
      ref_waddr = idx_q;
      ref_wdata = ex_ref_wdata;
    end
  end

  assign link_we    = do_exec && ex_push;
  assign link_wdata = {head_valid, head_idx};

  rcpa_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (PAGE_COUNT)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (ref_waddr),
    .wdata (ref_wdata),
    .raddr (rd_addr),
    .rdata (ref_rdata)
  );

  rcpa_ram #(
    .WIDTH (IDX_W + 1),
    .DEPTH (PAGE_COUNT)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (idx_q),
    .wdata (link_wdata),
    .raddr (rd_addr),
    .rdata (link_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      low_limit  <= '0;
      top_limit  <= LIMIT_W'(134217728);
      head_valid <= 1'b0;
      head_idx   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LOW_LIMIT: low_limit <= cfg_data;
          CFG_TOP_LIMIT: top_limit <= cfg_data;
          default: ;
        endcase
      end

      if (rsp_valid && !rsp_stall && !do_exec) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if (clr_idx == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            op_q   <= req.opcode;
            addr_q <= req.page_address;
            idx_q  <= rd_addr;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            rsp       <= ex_rsp;
            if (ex_pop) begin
              {head_valid, head_idx} <= link_rdata;
            end else if (ex_push) begin
              head_valid <= 1'b1;
              head_idx   <= idx_q;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RCPA_ASSERT_NEXT(a_accept_to_exec, clk, rst, req_fire, state == S_EXEC)
  `RCPA_ASSERT_NEXT(a_exec_gives_beat, clk, rst, do_exec, rsp_valid)
  `RCPA_ASSERT_NOW(a_freed_is_ok, clk, rst, rsp_valid && rsp.page_freed, rsp.status == ST_OK)
  `RCPA_ASSERT_NOW(a_alloc_addr_ok, clk, rst, rsp_valid && |rsp.alloc_address, rsp.status == ST_OK)

endmodule

// File: src/rcpa_ram.sv
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module rcpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
